@@ sv/ddo_pkg.sv @@
// Shared types, constants and the arctangent table of the odometry block.
`timescale 1ns / 1ps

package ddo_pkg;

    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_MAX_STAGES = 24;

    localparam int CFG_W     = 24;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int ANG_P_W   = 49;
    localparam int POS_W     = 32;
    localparam int HEAD_W    = 16;
    localparam int DMAG_W    = 50;

    localparam int HALF_DIVISOR = 2;
    localparam logic [31:0] CORDIC_K_Q30 = 32'd652032875;

    localparam logic [0:0] REG_TRAVEL_PER_COUNT = 1'b0;
    localparam logic [0:0] REG_TURN_GAIN        = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SUM,
        OP_DIF,
        OP_TLO,
        OP_THI,
        OP_ANG,
        OP_ROT,
        OP_XLO,
        OP_XHI,
        OP_XACC,
        OP_YLO,
        OP_YHI,
        OP_YACC,
        OP_LOAD
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIF,
        ST_TLO,
        ST_THI,
        ST_ANG,
        ST_ROT,
        ST_XLO,
        ST_XHI,
        ST_XACC,
        ST_YLO,
        ST_YHI,
        ST_YACC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] travel_per_count;
        logic [CFG_W-1:0] turn_gain;
    } t_cfg;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ sv/ddo_regs.sv @@
// APB-style configuration registers of the odometry block.
`timescale 1ns / 1ps

module ddo_regs
    import ddo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [CFG_W-1:0] r_travel_per_count;
    logic [CFG_W-1:0] r_turn_gain;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_travel_per_count <= '0;
            r_turn_gain        <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TRAVEL_PER_COUNT: r_travel_per_count <= pwdata[CFG_W-1:0];
                REG_TURN_GAIN:        r_turn_gain        <= pwdata[CFG_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TRAVEL_PER_COUNT: prdata = APB_DW'(r_travel_per_count);
            REG_TURN_GAIN:        prdata = APB_DW'(r_turn_gain);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.travel_per_count = r_travel_per_count;
    assign o_cfg.turn_gain        = r_turn_gain;

endmodule

@@ sv/ddo_ctrl.sv @@
// Sequencing state machine of the odometry block.
`timescale 1ns / 1ps

module ddo_ctrl
    import ddo_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    localparam int IW = $clog2(CORDIC_STAGES)
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_op           o_op,
    output logic [IW-1:0] o_iter
);

    t_state        r_state, n_state;
    logic [IW-1:0] r_iter, n_iter;
    logic          r_out_valid, n_out_valid;
    logic          slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_out_valid = r_out_valid && !i_out_ready;
        o_op        = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_CAPTURE;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_op    = OP_SUM;
                n_state = ST_DIF;
            end
            ST_DIF: begin
                o_op    = OP_DIF;
                n_state = ST_TLO;
            end
            ST_TLO: begin
                o_op    = OP_TLO;
                n_state = ST_THI;
            end
            ST_THI: begin
                o_op    = OP_THI;
                n_state = ST_ANG;
            end
            ST_ANG: begin
                o_op    = OP_ANG;
                n_iter  = '0;
                n_state = ST_ROT;
            end
            ST_ROT: begin
                o_op   = OP_ROT;
                n_iter = r_iter + IW'(1);
                if (r_iter == IW'(CORDIC_STAGES - 1)) begin
                    n_state = ST_XLO;
                end
            end
            ST_XLO: begin
                o_op    = OP_XLO;
                n_state = ST_XHI;
            end
            ST_XHI: begin
                o_op    = OP_XHI;
                n_state = ST_XACC;
            end
            ST_XACC: begin
                o_op    = OP_XACC;
                n_state = ST_YLO;
            end
            ST_YLO: begin
                o_op    = OP_YLO;
                n_state = ST_YHI;
            end
            ST_YHI: begin
                o_op    = OP_YHI;
                n_state = ST_YACC;
            end
            ST_YACC: begin
                o_op    = OP_YACC;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) begin
                    o_op        = OP_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_iter      = r_iter;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_SUM))
        else $error("accepted transfer did not start the sequence");
    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROT) |-> (32'(r_iter) < CORDIC_STAGES))
        else $error("rotation counter out of range");
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !i_out_ready)
        |=> (r_state == ST_DONE && r_out_valid))
        else $error("result overwrote a pending transfer");
`endif

endmodule

@@ sv/ddo_dpath.sv @@
// Datapath of the odometry block: shared multiplier, serial CORDIC, pose update.
`timescale 1ns / 1ps

module ddo_dpath
    import ddo_pkg::*;
#(
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    localparam int IW = $clog2(CORDIC_STAGES),
    localparam int CW = COUNT_WIDTH,
    localparam int SW = COUNT_WIDTH + CFG_W + 1
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  t_op                     i_op,
    input  logic [IW-1:0]           i_iter,
    input  logic signed [CW-1:0]    i_left_count_delta,
    input  logic signed [CW-1:0]    i_right_count_delta,
    output logic signed [POS_W-1:0] o_pose_x,
    output logic signed [POS_W-1:0] o_pose_y,
    output logic signed [HEAD_W-1:0] o_heading
);

    function automatic logic [POS_W-1:0] sat32(input logic [POS_W+19:0] v);
        logic [POS_W-1:0] res;
        if (!v[POS_W+19] && (v[POS_W+19:POS_W-1] != '0)) begin
            res = {1'b0, {(POS_W-1){1'b1}}};
        end else if (v[POS_W+19] && (v[POS_W+19:POS_W-1] != '1)) begin
            res = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

    logic [CW-1:0]          r_l, r_r;
    logic [SW-1:0]          r_sm;
    logic                   r_sneg;
    logic [ANG_P_W-1:0]     r_q;
    logic [ANG_P_W-1:0]     r_p;
    logic [HEAD_W-1:0]      r_full;
    logic signed [31:0]     r_x, r_y;
    logic [31:0]            r_z;
    logic [63:0]            r_lo;
    logic [DMAG_W-1:0]      r_dmag;
    logic                   r_dneg;
    logic [POS_W-1:0]       r_px, r_py;
    logic [HEAD_W-1:0]      r_head;

    logic [CW:0]            sum_w, dif_w, sum_mag, dif_mag;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [MUL_P_W-1:0]     mul_p;
    logic [MUL_P_W-1:0]     q_full;
    logic [ANG_P_W-1:0]     p_round_f, p_round_h;
    logic [HEAD_W-1:0]      half, mid;
    logic [31:0]            z_mid, z_fold;
    logic signed [31:0]     xs, ys;
    logic [31:0]            c_mag, atan_v;
    logic [63:0]            hi_sum;
    logic [POS_W+19:0]      disp, pos_sum;
    logic                   acc_y;

    assign sum_w   = {r_l[CW-1], r_l} + {r_r[CW-1], r_r};
    assign dif_w   = {r_r[CW-1], r_r} - {r_l[CW-1], r_l};
    assign sum_mag = sum_w[CW] ? (~sum_w + (CW+1)'(1)) : sum_w;
    assign dif_mag = dif_w[CW] ? (~dif_w + (CW+1)'(1)) : dif_w;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_op)
            OP_SUM: begin
                mul_a = MUL_A_W'(sum_mag);
                mul_b = MUL_B_W'(i_cfg.travel_per_count);
            end
            OP_DIF: begin
                mul_a = MUL_A_W'(dif_mag);
                mul_b = MUL_B_W'(i_cfg.travel_per_count);
            end
            OP_TLO: begin
                mul_a = MUL_A_W'(r_q[24:0]);
                mul_b = MUL_B_W'(i_cfg.turn_gain);
            end
            OP_THI: begin
                mul_a = MUL_A_W'(r_q[ANG_P_W-1:25]);
                mul_b = MUL_B_W'(i_cfg.turn_gain);
            end
            OP_XLO, OP_YLO: begin
                mul_a = MUL_A_W'(r_sm[31:0]);
                mul_b = c_mag;
            end
            OP_XHI, OP_YHI: begin
                mul_a = MUL_A_W'(r_sm >> 32);
                mul_b = c_mag;
            end
            default: ;
        endcase
    end

    assign mul_p  = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    assign q_full = dif_w[CW] ? (~mul_p + MUL_P_W'(1)) : mul_p;

    assign acc_y  = (i_op == OP_YLO) || (i_op == OP_YHI) || (i_op == OP_YACC);
    assign c_mag  = acc_y ? (r_y[31] ? (~r_y + 32'd1) : r_y)
                          : (r_x[31] ? (~r_x + 32'd1) : r_x);

    assign p_round_f = r_p + (ANG_P_W'(1) << 31);
    assign p_round_h = r_p + (ANG_P_W'(1) << (32 + HALF_DIVISOR - 2));
    assign half      = p_round_h[32+HALF_DIVISOR-1 +: HEAD_W];
    assign mid       = r_head + half;
    assign z_mid     = {mid, 16'h0000};
    assign z_fold    = z_mid + 32'h40000000;

    assign xs     = r_x >>> i_iter;
    assign ys     = r_y >>> i_iter;
    assign atan_v = atan_lut(5'(i_iter));

    assign hi_sum  = mul_p[63:0] + 64'(r_lo[63:32]);
    assign disp    = r_dneg ? (~(POS_W+20)'(r_dmag) + (POS_W+20)'(1)) : (POS_W+20)'(r_dmag);
    assign pos_sum = (acc_y ? {{20{r_py[POS_W-1]}}, r_py} : {{20{r_px[POS_W-1]}}, r_px})
                   + disp;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_CAPTURE: begin
                r_l <= i_left_count_delta;
                r_r <= i_right_count_delta;
            end
            OP_SUM: begin
                r_sm   <= mul_p[SW-1:0];
                r_sneg <= sum_w[CW];
            end
            OP_DIF: r_q <= q_full[ANG_P_W-1:0];
            OP_TLO: r_p <= mul_p[ANG_P_W-1:0];
            OP_THI: r_p <= r_p + {mul_p[23:0], 25'd0};
            OP_ANG: begin
                r_full <= p_round_f[32 +: HEAD_W];
                r_y    <= '0;
                if (z_fold[31]) begin
                    r_x <= -$signed(CORDIC_K_Q30);
                    r_z <= z_mid + 32'h80000000;
                end else begin
                    r_x <= $signed(CORDIC_K_Q30);
                    r_z <= z_mid;
                end
            end
            OP_ROT: begin
                if (r_z[31]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_v;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_v;
                end
            end
            OP_XLO: r_lo <= mul_p[63:0] + (64'd1 << 38);
            OP_YLO: r_lo <= mul_p[63:0] + (64'd1 << 38);
            OP_XHI: begin
                r_dmag <= hi_sum[7 +: DMAG_W];
                r_dneg <= r_sneg ^ r_x[31];
            end
            OP_YHI: begin
                r_dmag <= hi_sum[7 +: DMAG_W];
                r_dneg <= r_sneg ^ r_y[31];
            end
            OP_LOAD: begin
                o_pose_x  <= r_px;
                o_pose_y  <= r_py;
                o_heading <= r_head;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px   <= '0;
            r_py   <= '0;
            r_head <= '0;
        end else begin
            unique case (i_op)
                OP_XACC: r_px <= sat32(pos_sum);
                OP_YACC: begin
                    r_py   <= sat32(pos_sum);
                    r_head <= r_head + r_full;
                end
                default: ;
            endcase
        end
    end

endmodule

@@ sv/diff_drive_odometry.sv @@
// Top level of the differential-drive odometry block.
// Dead-reckoning pose tracker: each transfer of left and right encoder count
// deltas updates x, y (signed Q16.16 m, saturating) and heading (binary angle,
// wrapping) by the midpoint method, and one pose transfer follows. An item
// passes through four products on the one shared 33x32 multiplier, the
// CORDIC_STAGES iterations of the serial CORDIC and four more products for
// the displacements before the next item is accepted. A new item is taken
// while a finished pose still waits at the output register. Configuration:
// travel_per_count at 0x0, turn_gain at 0x4.
`timescale 1ns / 1ps

module diff_drive_odometry
    import ddo_pkg::*;
#(
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_AW-1:0]            paddr,
    input  logic [APB_DW-1:0]            pwdata,
    output logic [APB_DW-1:0]            prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COUNT_WIDTH-1:0] i_left_count_delta,
    input  logic signed [COUNT_WIDTH-1:0] i_right_count_delta,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [POS_W-1:0]      o_pose_x,
    output logic signed [POS_W-1:0]      o_pose_y,
    output logic signed [HEAD_W-1:0]     o_heading
);

    localparam int IW = $clog2(CORDIC_STAGES);

    t_cfg          cfg;
    t_op           op;
    logic [IW-1:0] iter;

    ddo_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ddo_ctrl #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_op        (op),
        .o_iter      (iter)
    );

    ddo_dpath #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_op                (op),
        .i_iter              (iter),
        .i_left_count_delta  (i_left_count_delta),
        .i_right_count_delta (i_right_count_delta),
        .o_pose_x            (o_pose_x),
        .o_pose_y            (o_pose_y),
        .o_heading           (o_heading)
    );

endmodule
